// ----- design/gfba_pkg.sv -----
// Shared codes and widths for the grouped free-block allocator.
package gfba_pkg;

   localparam int STATUS_W = 2;
   localparam int FIELD_W  = 16;
   localparam int LEVEL_W  = 7;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOSPACE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_REJECT  = 2'd2;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam int STATE_W = 2;
   localparam logic [STATE_W-1:0] ST_IDLE   = 2'd0;
   localparam logic [STATE_W-1:0] ST_ALLOC  = 2'd1;
   localparam logic [STATE_W-1:0] ST_SPILL  = 2'd2;
   localparam logic [STATE_W-1:0] ST_REFILL = 2'd3;

endpackage

// ----- design/grouped_free_block_allocator.sv -----
// Responses: a push or a rejected command answers in the cycle after acceptance, an allocate
// from the ALLOC state after the registered stack read, and a spilling free once SPILL is done.
// Throughput: one push or rejected command a cycle; an allocate holds busy in ALLOC, a spill
// keeps busy high while it copies the stack out, and a refill after the emptying allocate while
// it copies a group back, one entry a cycle through the single read port of each memory.
// Reset: synchronous; clears the stack and group counts, memories are not cleared.
// The receiver cannot stall: each response is on the rsp_ ports for one cycle.
module grouped_free_block_allocator import gfba_pkg::*; #(
   parameter int STACK_DEPTH = 100,
   parameter int GROUP_DEPTH = 64,
   parameter int BLOCK_BITS  = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_opcode,
   input  logic [FIELD_W-1:0]  req_block_number,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [FIELD_W-1:0]  rsp_granted_block,
   output logic [LEVEL_W-1:0]  rsp_stack_level
);

   localparam int ADDR_W  = $clog2(STACK_DEPTH);
   localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
   localparam int GC_W    = $clog2(GROUP_DEPTH + 1);
   localparam int GADDR_W = $clog2(GROUP_DEPTH * STACK_DEPTH);
   localparam int BASE_W  = $clog2(GROUP_DEPTH * STACK_DEPTH + 1);
   localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(STACK_DEPTH);
   localparam logic [GC_W-1:0]   GC_FULL   = GC_W'(GROUP_DEPTH);
   localparam logic [ADDR_W-1:0] IDX_LAST  = ADDR_W'(STACK_DEPTH - 1);
   localparam logic [BASE_W-1:0] BASE_STEP = BASE_W'(STACK_DEPTH);

   logic [STATE_W-1:0]    state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [GC_W-1:0]       gc_ff, gc_in;
   logic [BASE_W-1:0]     base_ff, base_in;
   logic [ADDR_W-1:0]     idx_ff, idx_in;
   logic [BLOCK_BITS-1:0] pend_ff, pend_in;
   logic                  valid_ff, valid_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [FIELD_W-1:0]    granted_ff, granted_in;
   logic [CNT_W-1:0]      level_ff, level_in;

   logic                  accept;
   logic [BLOCK_BITS-1:0] blk;
   logic [FIELD_W+BLOCK_BITS-1:0] blk_ext;
   logic [FIELD_W+BLOCK_BITS-1:0] gnt_ext;
   logic [CNT_W+LEVEL_W-1:0]      level_ext;
   logic [BASE_W-1:0]     gaddr_sum;

   logic                  s_wr_en;
   logic [ADDR_W-1:0]     s_wr_addr, s_rd_addr;
   logic [BLOCK_BITS-1:0] s_wr_data, s_rd_data;
   logic                  g_wr_en;
   logic [GADDR_W-1:0]    g_wr_addr, g_rd_addr;
   logic [BLOCK_BITS-1:0] g_rd_data;

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign blk_ext = {{BLOCK_BITS{1'b0}}, req_block_number};
   assign blk     = blk_ext[BLOCK_BITS-1:0];
   assign gnt_ext = {{FIELD_W{1'b0}}, s_rd_data};
   assign gaddr_sum = base_ff + BASE_W'(idx_ff);

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      gc_in      = gc_ff;
      base_in    = base_ff;
      idx_in     = idx_ff;
      pend_in    = pend_ff;
      valid_in   = 1'b0;
      status_in  = status_ff;
      granted_in = granted_ff;
      level_in   = level_ff;
      s_wr_en    = 1'b0;
      s_wr_addr  = count_ff[ADDR_W-1:0];
      s_wr_data  = blk;
      s_rd_addr  = '0;
      g_wr_en    = 1'b0;
      g_wr_addr  = gaddr_sum[GADDR_W-1:0];
      g_rd_addr  = gaddr_sum[GADDR_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            s_rd_addr = ADDR_W'(count_ff - CNT_W'(1));
            if (accept) begin
               granted_in = '0;
               if (req_opcode == OP_ALLOC) begin
                  if (count_ff == '0 || count_ff > CNT_FULL) begin
                     valid_in  = 1'b1;
                     status_in = STATUS_NOSPACE;
                     level_in  = count_ff;
                  end else begin
                     count_in = count_ff - CNT_W'(1);
                     state_in = ST_ALLOC;
                  end
               end else if (blk == '0) begin
                  valid_in  = 1'b1;
                  status_in = STATUS_REJECT;
                  level_in  = count_ff;
               end else if (count_ff >= CNT_FULL) begin
                  if (gc_ff >= GC_FULL) begin
                     valid_in  = 1'b1;
                     status_in = STATUS_REJECT;
                     level_in  = count_ff;
                  end else begin
                     s_rd_addr = '0;
                     idx_in    = '0;
                     pend_in   = blk;
                     state_in  = ST_SPILL;
                  end
               end else begin
                  s_wr_en   = 1'b1;
                  count_in  = count_ff + CNT_W'(1);
                  valid_in  = 1'b1;
                  status_in = STATUS_OK;
                  level_in  = count_ff + CNT_W'(1);
               end
            end
         end
         ST_ALLOC: begin
            valid_in   = 1'b1;
            status_in  = STATUS_OK;
            granted_in = gnt_ext[FIELD_W-1:0];
            level_in   = count_ff;
            state_in   = ST_IDLE;
            if (count_ff == '0 && gc_ff != '0 && gc_ff <= GC_FULL) begin
               gc_in     = gc_ff - GC_W'(1);
               base_in   = base_ff - BASE_STEP;
               count_in  = CNT_FULL;
               level_in  = CNT_FULL;
               idx_in    = '0;
               g_rd_addr = GADDR_W'(base_ff - BASE_STEP);
               state_in  = ST_REFILL;
            end
         end
         ST_SPILL: begin
            g_wr_en   = 1'b1;
            s_rd_addr = idx_ff + ADDR_W'(1);
            idx_in    = idx_ff + ADDR_W'(1);
            if (idx_ff == IDX_LAST) begin
               s_wr_en    = 1'b1;
               s_wr_addr  = '0;
               s_wr_data  = pend_ff;
               gc_in      = gc_ff + GC_W'(1);
               base_in    = base_ff + BASE_STEP;
               count_in   = CNT_W'(1);
               valid_in   = 1'b1;
               status_in  = STATUS_OK;
               level_in   = CNT_W'(1);
               state_in   = ST_IDLE;
            end
         end
         ST_REFILL: begin
            s_wr_en   = 1'b1;
            s_wr_addr = idx_ff;
            s_wr_data = g_rd_data;
            g_rd_addr = GADDR_W'(gaddr_sum + BASE_W'(1));
            idx_in    = idx_ff + ADDR_W'(1);
            if (idx_ff == IDX_LAST) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         gc_ff    <= '0;
         base_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         gc_ff    <= gc_in;
         base_ff  <= base_in;
         valid_ff <= valid_in;
      end
      idx_ff     <= idx_in;
      pend_ff    <= pend_in;
      status_ff  <= status_in;
      granted_ff <= granted_in;
      level_ff   <= level_in;
   end

   gfba_ram #(
      .DEPTH (STACK_DEPTH),
      .WIDTH (BLOCK_BITS)
   ) u_stack (
      .clock   (clock),
      .wr_en   (s_wr_en),
      .wr_addr (s_wr_addr),
      .wr_data (s_wr_data),
      .rd_addr (s_rd_addr),
      .rd_data (s_rd_data)
   );

   gfba_ram #(
      .DEPTH (GROUP_DEPTH * STACK_DEPTH),
      .WIDTH (BLOCK_BITS)
   ) u_groups (
      .clock   (clock),
      .wr_en   (g_wr_en),
      .wr_addr (g_wr_addr),
      .wr_data (s_rd_data),
      .rd_addr (g_rd_addr),
      .rd_data (g_rd_data)
   );

   assign level_ext         = {{LEVEL_W{1'b0}}, level_ff};
   assign rsp_valid         = valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_granted_block = granted_ff;
   assign rsp_stack_level   = level_ext[LEVEL_W-1:0];

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL && gc_ff <= GC_FULL)
      else $error("stack or group count out of range");

   a_base_track: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> base_ff == BASE_W'(gc_ff) * BASE_STEP)
      else $error("group base out of step with group count");

   a_empty_alloc: assert property (@(posedge clock) disable iff (reset)
      accept && req_opcode == OP_ALLOC && count_ff == '0
      |=> rsp_valid && rsp_status == STATUS_NOSPACE && rsp_granted_block == '0)
      else $error("allocate on empty stack not refused");

   a_free_no_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_granted_block == '0)
      else $error("failed command granted a block");
`endif

endmodule

// ----- design/gfba_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
module gfba_ram import gfba_pkg::*; #(
   parameter int DEPTH = 100,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
